/* design/lius_pkg.sv */
// Shared types and constants for the linear interpolation upsampler.
`default_nettype none

package lius_pkg;

    // Sample width of the data path
    localparam int SAMPLE_BITS = 24;

    // Factor register
    localparam int              FACTOR_BITS  = 7;
    localparam logic [6:0]      FACTOR_RESET = 7'd4;
    localparam logic [2:0]      ADDR_FACTOR  = 3'd0;

    // Quotient bits resolved per divider cycle
    localparam int DIV_DIGIT = 8;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          starts_trial;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] interp_value;
        logic                          last_of_run;
    } out_item_t;

endpackage

`default_nettype wire

/* design/lius_front.sv */
// Front end: takes samples, keeps the stored sample and divides the step by L.
`default_nettype none

module lius_front
    import lius_pkg::*;
#(
    parameter int MAX_FACTOR = 64,
    parameter int FW         = 7,
    parameter int EW         = 2 * SAMPLE_BITS + 1 + 2 * FW
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_data,
    input  wire logic [FACTOR_BITS-1:0] factor,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output logic [EW-1:0]               push_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int NSTEP = (SB + DIV_DIGIT - 1) / DIV_DIGIT;
    localparam int NB    = NSTEP * DIV_DIGIT;
    localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t          state_reg;
    logic            have_reg;
    logic [CW-1:0]   step_reg;

    logic [SB-1:0]   prev_reg;
    logic [SB-1:0]   base_reg;
    logic            neg_reg;
    logic [NB-1:0]   num_reg;
    logic [NB-1:0]   quo_reg;
    logic [FW-1:0]   rem_reg;
    logic [FW-1:0]   l_reg;

    logic [NB-1:0]   num_next;
    logic [NB-1:0]   quo_next;
    logic [FW-1:0]   rem_next;

    logic [FW-1:0]   fac_eff;
    logic            in_fire;
    logic            store_only;
    logic [SB:0]     diff;
    logic [SB:0]     mag;
    logic [SB:0]     qm_ext;
    logic [SB:0]     qd;
    logic [FW-1:0]   rd;

    // Effective factor: zero acts as one, large values clamp to the maximum
    always_comb
    begin
        if (factor == '0)
            fac_eff = FW'(1);
        else if (int'(factor) > MAX_FACTOR)
            fac_eff = FW'(MAX_FACTOR);
        else
            fac_eff = FW'(factor);
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign store_only = in_data.starts_trial || !have_reg;

    // Step between stored and new sample, and its magnitude
    assign diff = {in_data.sample_value[SB-1], in_data.sample_value}
                - {prev_reg[SB-1], prev_reg};
    assign mag  = diff[SB] ? (~diff + 1'b1) : diff;

    // Restoring division, DIV_DIGIT quotient bits per cycle
    always_comb
    begin
        logic [FW:0] trial;
        rem_next = rem_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_DIGIT; i++)
        begin
            trial    = {rem_next, num_next[NB-1]};
            num_next = num_next << 1;
            if (trial >= {1'b0, l_reg})
            begin
                rem_next = FW'(trial - {1'b0, l_reg});
                quo_next = {quo_next[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[FW-1:0];
                quo_next = {quo_next[NB-2:0], 1'b0};
            end
        end
    end

    // Floor for negative step: q = -qm - 1, r = L - rm; if rm = 0, q = -qm, r = 0
    assign qm_ext = {1'b0, quo_reg[SB-1:0]};
    always_comb
    begin
        if (!neg_reg)
        begin
            qd = qm_ext;
            rd = rem_reg;
        end
        else if (rem_reg == '0)
        begin
            qd = ~qm_ext + 1'b1;
            rd = '0;
        end
        else
        begin
            qd = ~qm_ext;
            rd = l_reg - rem_reg;
        end
    end

    assign push_valid = (state_reg == ST_PUSH);
    assign push_data  = {base_reg, qd, rd, l_reg};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            have_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        have_reg <= 1'b1;
                        step_reg <= '0;
                        if (!store_only)
                            state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == CW'(NSTEP - 1))
                        state_reg <= ST_PUSH;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_PUSH:
                begin
                    if (push_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prev_reg <= in_data.sample_value;
            base_reg <= prev_reg;
            neg_reg  <= diff[SB];
            num_reg  <= NB'(mag[SB-1:0]);
            quo_reg  <= '0;
            rem_reg  <= '0;
            l_reg    <= fac_eff;
        end
        else if (state_reg == ST_DIV)
        begin
            num_reg <= num_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* design/lius_queue.sv */
// Two-entry queue between the front end and the result generator.
`default_nettype none

module lius_queue #(
    parameter int WIDTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push_fire && !pop_fire)
                count_reg <= count_reg + 1'b1;
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* design/lius_back.sv */
// Result generator: steps quotient and remainder to emit L interpolated values.
`default_nettype none

module lius_back
    import lius_pkg::*;
#(
    parameter int FW = 7,
    parameter int EW = 2 * SAMPLE_BITS + 1 + 2 * FW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire logic [EW-1:0] pop_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output out_item_t          out_data
);

    localparam int SB = SAMPLE_BITS;

    logic            active_reg;
    logic [FW-1:0]   k_reg;
    logic            out_valid_reg;
    out_item_t       out_data_reg;

    logic [SB-1:0]   base_reg;
    logic [SB:0]     qd_reg;
    logic [FW-1:0]   rd_reg;
    logic [FW-1:0]   l_reg;
    logic [SB:0]     q_reg;
    logic [FW-1:0]   r_reg;

    logic [SB:0]     q_next;
    logic [FW-1:0]   r_next;
    logic [FW:0]     r_sum;
    logic [SB:0]     value;
    logic            emit;
    logic            last;
    logic            pop_fire;

    assign emit      = active_reg && (!out_valid_reg || out_ready);
    assign last      = (k_reg == l_reg - 1'b1);
    assign pop_ready = !active_reg || (emit && last);
    assign pop_fire  = pop_valid && pop_ready;

    // Current result: stored sample plus accumulated quotient
    assign value = {base_reg[SB-1], base_reg} + q_reg;

    // Next k: add the step's quotient and remainder, carry on remainder wrap
    assign r_sum = {1'b0, r_reg} + {1'b0, rd_reg};
    always_comb
    begin
        if (r_sum >= {1'b0, l_reg})
        begin
            r_next = FW'(r_sum - {1'b0, l_reg});
            q_next = q_reg + qd_reg + 1'b1;
        end
        else
        begin
            r_next = r_sum[FW-1:0];
            q_next = q_reg + qd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (pop_fire)
            begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end
            else if (emit)
            begin
                k_reg <= k_reg + 1'b1;
                if (last)
                    active_reg <= 1'b0;
            end
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.interp_value <= value[SB-1:0];
            out_data_reg.last_of_run  <= last;
        end

        if (pop_fire)
        begin
            l_reg    <= pop_data[FW-1:0];
            rd_reg   <= pop_data[2*FW-1:FW];
            qd_reg   <= pop_data[2*FW+SB:2*FW];
            base_reg <= pop_data[EW-1:2*FW+SB+1];
            q_reg    <= '0;
            r_reg    <= '0;
        end
        else if (emit)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

`ifndef ASSERT_OFF
    // Remainder stays reduced while a run is in progress
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (r_reg < l_reg))
        else $error("remainder not below factor");

    // Run index never passes the factor
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (k_reg < l_reg))
        else $error("run index out of range");

    // A new entry starts a fresh run
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire |=> (active_reg && k_reg == '0))
        else $error("run did not restart on new entry");
`endif

endmodule

`default_nettype wire

/* design/linear_interp_upsampler_core.sv */
// Top level of the linear interpolation upsampler with its APB register.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    in_item_t  (sample_value, starts_trial)
//  out       source     out_valid / out_ready  out_item_t (interp_value, last_of_run)
//  apb       slave      psel / penable         upsample_factor at address 0
//
// A stored-only sample is only accepted and stored. Any other sample passes the front
// end as accept, radix-256 division, queue push, and no new sample is taken until it
// is pushed; its L results then leave at one per cycle unless the output stalls.
// Reset is asynchronous; no clearing pass is needed. A stalled output holds its
// transfer; the two-entry queue lets the front end keep dividing meanwhile.
`default_nettype none

module linear_interp_upsampler_core
    import lius_pkg::*;
#(
    parameter int MAX_FACTOR = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int EW = 2 * SAMPLE_BITS + 1 + 2 * FW;

    logic [FACTOR_BITS-1:0] factor_reg;
    logic                   push_valid;
    logic                   push_ready;
    logic [EW-1:0]          push_data;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [EW-1:0]          pop_data;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FACTOR) ? {{(32-FACTOR_BITS){1'b0}}, factor_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            factor_reg <= FACTOR_RESET;
        else if (psel && penable && pwrite && pready && paddr == ADDR_FACTOR)
            factor_reg <= pwdata[FACTOR_BITS-1:0];
    end

    lius_front #(
        .MAX_FACTOR (MAX_FACTOR),
        .FW         (FW),
        .EW         (EW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .factor     (factor_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lius_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lius_back #(
        .FW (FW),
        .EW (EW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
